>>> rtl/crcz_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcz_pkg
// Shared types, register indexes and the reflected CRC-32C byte update.
// ----------------------------------------------------------------------------
package crcz_pkg;

    localparam int unsigned MaxBlockBytesDefault = 65536;
    localparam logic [31:0] PolyReflected        = 32'h82F6_3B78;
    localparam logic [31:0] SeedReset            = 32'hFFFF_FFFE;
    localparam logic [15:0] OffsetReset          = 16'h0000;
    localparam logic        EnableReset          = 1'b1;
    localparam int unsigned FieldBytes           = 4;
    localparam int unsigned CfgIdxW              = 2;
    localparam int unsigned CfgDataW             = 32;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SEED   = 2'd0,
        CFG_OFFSET = 2'd1,
        CFG_ENABLE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] seed_value;
        logic [15:0] field_offset;
        logic        zero_field_enable;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic [31:0] crc_value;
        logic        field_overrun;
    } t_result;

    typedef struct packed {
        logic at_start;
    } t_status;

    // eight shift steps of the reflected crc over one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ PolyReflected;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> rtl/crcz_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcz_engine
// Running CRC and byte position per block, field zeroing and overrun check.
// ----------------------------------------------------------------------------
module crcz_engine
    import crcz_pkg::*;
#(
    parameter int unsigned MAX_BLOCK_BYTES = MaxBlockBytesDefault
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result,
    output t_status o_status
);

    localparam int unsigned PosW = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int unsigned CmpW = (PosW > 17) ? PosW : 17;
    localparam logic [PosW-1:0] PosMax = PosW'(MAX_BLOCK_BYTES);

    logic [31:0]     r_crc, n_crc;
    logic [PosW-1:0] r_pos, n_pos;

    logic [PosW-1:0] w_pos_inc;
    logic [CmpW-1:0] w_pos_ext;
    logic [CmpW-1:0] w_off_ext;
    logic [CmpW-1:0] w_end_ext;
    logic            w_in_field;
    logic [7:0]      w_byte;
    logic [31:0]     w_crc_in;
    logic [31:0]     w_crc_out;

    always_comb begin
        w_pos_inc  = (r_pos == PosMax) ? r_pos : r_pos + PosW'(1);
        w_pos_ext  = CmpW'(r_pos);
        w_off_ext  = CmpW'(i_cfg.field_offset);
        w_end_ext  = w_off_ext + CmpW'(FieldBytes);
        w_in_field = i_cfg.zero_field_enable && (w_pos_ext >= w_off_ext)
                     && (w_pos_ext < w_end_ext);
        w_byte     = w_in_field ? 8'd0 : i_item.data_byte;
        w_crc_in   = (r_pos == '0) ? i_cfg.seed_value : r_crc;
        w_crc_out  = crc_byte(w_crc_in, w_byte);

        o_result.crc_value     = w_crc_out;
        o_result.field_overrun = i_cfg.zero_field_enable && (CmpW'(w_pos_inc) < w_end_ext);
        o_status.at_start      = (r_pos == '0);

        n_crc = r_crc;
        n_pos = r_pos;
        if (i_step) begin
            if (i_item.last_byte) begin
                n_crc = '0;
                n_pos = '0;
            end else begin
                n_crc = w_crc_out;
                n_pos = w_pos_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= '0;
            r_pos <= '0;
        end else begin
            r_crc <= n_crc;
            r_pos <= n_pos;
        end
    end

endmodule
`default_nettype wire

>>> rtl/crc32c_with_zeroed_field.sv
// pipeline: each accepted byte is held in the input register; a last byte's result is registered in the output register
// throughput: one byte per cycle, set by the byte-wide crc xor network in the engine,
// except that a last byte stalls in the input register under backpressure; other bytes advance
// reset: synchronous active low; clears pipeline valids, crc state and block position
// reset loads seed 0xFFFFFFFE, field offset 0 and zeroing enabled
`default_nettype none
// ----------------------------------------------------------------------------
// crc32c_with_zeroed_field
// Streaming reflected CRC-32C with an optional zeroed four-byte field.
// ----------------------------------------------------------------------------
module crc32c_with_zeroed_field
    import crcz_pkg::*;
#(
    parameter int unsigned MAX_BLOCK_BYTES = MaxBlockBytesDefault
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [CfgIdxW-1:0]   i_cfg_idx,
    input  wire [CfgDataW-1:0]  i_cfg_wdata,
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    input  wire [7:0]           i_s_tdata,   // [7:0] data_byte
    input  wire                 i_s_tlast,   // last_byte
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output logic [31:0]         o_m_tdata,   // [31:0] crc_value
    output logic                o_m_tuser    // field_overrun
);

    t_cfg    r_cfg;
    t_item   r_s1_item;
    logic    r_s1_valid, n_s1_valid;
    logic    r_out_valid, n_out_valid;
    t_result r_out;
    t_result w_result;
    t_status w_status;
    logic    w_out_free;
    logic    w_s1_adv;
    logic    w_in_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seed_value        <= SeedReset;
            r_cfg.field_offset      <= OffsetReset;
            r_cfg.zero_field_enable <= EnableReset;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SEED:   r_cfg.seed_value        <= i_cfg_wdata[31:0];
                CFG_OFFSET: r_cfg.field_offset      <= i_cfg_wdata[15:0];
                CFG_ENABLE: r_cfg.zero_field_enable <= i_cfg_wdata[0];
                default:    r_cfg                   <= r_cfg;
            endcase
        end
    end

    always_comb begin
        w_out_free  = !r_out_valid || i_m_tready;
        w_s1_adv    = r_s1_valid && (!r_s1_item.last_byte || w_out_free);
        o_s_tready  = !r_s1_valid || w_s1_adv;
        w_in_acc    = i_s_tvalid && o_s_tready;
        n_s1_valid  = w_in_acc || (r_s1_valid && !w_s1_adv);
        n_out_valid = (w_s1_adv && r_s1_item.last_byte) || (r_out_valid && !i_m_tready);
    end

    crcz_engine #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_s1_adv),
        .i_item   (r_s1_item),
        .i_cfg    (r_cfg),
        .o_result (w_result),
        .o_status (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_item.data_byte <= i_s_tdata;
            r_s1_item.last_byte <= i_s_tlast;
        end
        if (w_s1_adv && r_s1_item.last_byte) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out.crc_value;
    assign o_m_tuser  = r_out.field_overrun;

`ifndef ASSERT_OFF
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_s_tready)
        else $error("input stage empty but not ready");

    a_no_result_mid_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1_item.last_byte && w_out_free) |=> !o_m_tvalid)
        else $error("result produced for a byte that is not last");

    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && r_s1_item.last_byte) |=> w_status.at_start)
        else $error("block position not cleared after last byte");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");
`endif

endmodule
`default_nettype wire
